@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// ASSERT_IMPL: consequent must hold in the same cycle as the antecedent.
// ASSERT_NEXT: consequent must hold one cycle after the antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/fbf_pkg.sv @@
package fbf_pkg;

  // Field widths
  localparam int POS_W   = 16;
  localparam int ID_W    = 32;
  localparam int COORD_W = 18;
  localparam int INV_W   = 24;
  localparam int CNT_W   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRACK    = 3'd4;

  // Register reset values
  localparam logic [POS_W-1:0] CENTER_X_RST  = 16'd23808;
  localparam logic [POS_W-1:0] CENTER_Y_RST  = 16'd15360;
  localparam logic [INV_W-1:0] INV_FOCAL_RST = 24'd41943;
  localparam logic [POS_W-1:0] MAX_TRACK_RST = 16'd6400;

endpackage

@@ hw/rtl/fbf_if.sv @@
// Request channel: one tracked feature pair
interface fbf_in_if;
  logic                       valid;
  logic                       ready;
  logic [fbf_pkg::POS_W-1:0]  prev_x;
  logic [fbf_pkg::POS_W-1:0]  prev_y;
  logic [fbf_pkg::POS_W-1:0]  now_x;
  logic [fbf_pkg::POS_W-1:0]  now_y;
  logic [fbf_pkg::ID_W-1:0]   feature_id;
  logic                       is_new;
  logic                       frame_start;

  modport source (
    output valid, prev_x, prev_y, now_x, now_y, feature_id, is_new, frame_start,
    input  ready
  );
  modport sink (
    input  valid, prev_x, prev_y, now_x, now_y, feature_id, is_new, frame_start,
    output ready
  );
endinterface

// Result channel: one kept feature
interface fbf_out_if;
  logic                               valid;
  logic                               ready;
  logic [fbf_pkg::ID_W-1:0]           kept_id;
  logic signed [fbf_pkg::COORD_W-1:0] now_u;
  logic signed [fbf_pkg::COORD_W-1:0] now_v;
  logic signed [fbf_pkg::COORD_W-1:0] prev_u;
  logic signed [fbf_pkg::COORD_W-1:0] prev_v;
  logic                               prev_valid;

  modport source (
    output valid, kept_id, now_u, now_v, prev_u, prev_v, prev_valid,
    input  ready
  );
  modport sink (
    input  valid, kept_id, now_u, now_v, prev_u, prev_v, prev_valid,
    output ready
  );
endinterface

@@ hw/rtl/feature_bucket_filter.sv @@
// Feature bucketing filter. One tracked feature request is taken per clock
// unless the output stalls; a kept feature's result passes one compute
// stage, then the output register, and a dropped one yields nothing. This
// rate holds as the per-cell count memory is read in the accepting cycle and
// written back when a kept request leaves the compute stage; a write-to-read
// forward covers back-to-back requests to the same cell. A valid flag per
// cell, held in flip-flops, is cleared at once on frame start, so the block
// needs no clearing pass after reset or per frame. Configuration registers
// must be written through the write port while the block is idle, which the
// block does not enforce; a new max_track_dist acts via max_track_q, lim2_q.
`include "assert_macros.svh"

module feature_bucket_filter #(
  parameter int IMG_WIDTH    = 744,
  parameter int IMG_HEIGHT   = 480,
  parameter int X_CELLS      = 12,
  parameter int Y_CELLS      = 8,
  parameter int MAX_PER_CELL = 2,
  parameter int BORDER       = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fbf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  fbf_in_if.sink                          in_req,
  fbf_out_if.source                       out_res
);

  localparam int PosW     = fbf_pkg::POS_W;
  localparam int CntW     = fbf_pkg::CNT_W;
  localparam int CoordW   = fbf_pkg::COORD_W;
  localparam int ProdW    = PosW + 1 + fbf_pkg::INV_W + 1;
  localparam int NumCells = X_CELLS * Y_CELLS;
  localparam int AddrW    = (NumCells > 1) ? $clog2(NumCells) : 1;
  localparam int XCellW   = (X_CELLS > 1) ? $clog2(X_CELLS) : 1;
  localparam int YCellW   = (Y_CELLS > 1) ? $clog2(Y_CELLS) : 1;

  localparam logic [PosW-1:0] BordLo = PosW'(BORDER * 64);
  localparam logic [PosW-1:0] XHi    = PosW'((IMG_WIDTH - BORDER) * 64);
  localparam logic [PosW-1:0] YHi    = PosW'((IMG_HEIGHT - BORDER) * 64);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PER_CELL);

  localparam logic signed [CoordW-1:0] CoordMax = 18'sd131071;
  localparam logic signed [CoordW-1:0] CoordMin = -18'sd131072;

  // Round to nearest (ties up), drop 16 fraction bits, saturate to Q3.14
  function automatic logic signed [CoordW-1:0] round_sat(
    input logic signed [ProdW-1:0] prod
  );
    logic signed [ProdW-1:0] t;
    logic signed [ProdW-17:0] r;
    t = prod + ProdW'(32768);
    r = t[ProdW-1:16];
    if (r > (ProdW-16)'(CoordMax)) begin
      return CoordMax;
    end else if (r < (ProdW-16)'(CoordMin)) begin
      return CoordMin;
    end else begin
      return r[CoordW-1:0];
    end
  endfunction

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [PosW-1:0]          center_x_q, center_y_q, max_track_q;
  logic [fbf_pkg::INV_W-1:0] inv_fx_q, inv_fy_q;
  logic [2*PosW-1:0]        lim2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= fbf_pkg::CENTER_X_RST;
      center_y_q  <= fbf_pkg::CENTER_Y_RST;
      inv_fx_q    <= fbf_pkg::INV_FOCAL_RST;
      inv_fy_q    <= fbf_pkg::INV_FOCAL_RST;
      max_track_q <= fbf_pkg::MAX_TRACK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbf_pkg::REG_CENTER_X:    center_x_q  <= cfg_data_i[PosW-1:0];
        fbf_pkg::REG_CENTER_Y:    center_y_q  <= cfg_data_i[PosW-1:0];
        fbf_pkg::REG_INV_FOCAL_X: inv_fx_q    <= cfg_data_i;
        fbf_pkg::REG_INV_FOCAL_Y: inv_fy_q    <= cfg_data_i;
        fbf_pkg::REG_MAX_TRACK:   max_track_q <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // squared motion limit
  always_ff @(posedge clk_i) begin
    lim2_q <= max_track_q * max_track_q;
  end

  // -------------------------------------------------------------------------
  // Handshake
  // -------------------------------------------------------------------------
  logic b_valid_q, c_valid_q;
  logic b_adv, accept, keep_b, wr_en;

  assign b_adv        = b_valid_q && (!c_valid_q || out_res.ready);
  assign in_req.ready = !b_valid_q || b_adv;
  assign accept       = in_req.valid && in_req.ready;

  // -------------------------------------------------------------------------
  // Accept stage: cell index, squares, products, border test
  // -------------------------------------------------------------------------
  logic [XCellW-1:0] cx_a;
  logic [YCellW-1:0] cy_a;
  logic [AddrW-1:0]  idx_a;

  fbf_axis_cell #(
    .SIZE   (IMG_WIDTH),
    .CELLS  (X_CELLS),
    .BORDER (BORDER)
  ) u_cell_x (
    .pos_i  (in_req.prev_x),
    .cell_o (cx_a)
  );

  fbf_axis_cell #(
    .SIZE   (IMG_HEIGHT),
    .CELLS  (Y_CELLS),
    .BORDER (BORDER)
  ) u_cell_y (
    .pos_i  (in_req.prev_y),
    .cell_o (cy_a)
  );

  assign idx_a = AddrW'(int'(cy_a) * X_CELLS + int'(cx_a));

  logic signed [PosW:0]        dx_a, dy_a;
  logic signed [2*PosW+1:0]    sqx_a, sqy_a;
  logic signed [PosW:0]        dnu_a, dnv_a, dpu_a, dpv_a;
  logic signed [fbf_pkg::INV_W:0] ifx_s, ify_s;
  logic                        border_ok_a;

  assign dx_a  = $signed({1'b0, in_req.prev_x}) - $signed({1'b0, in_req.now_x});
  assign dy_a  = $signed({1'b0, in_req.prev_y}) - $signed({1'b0, in_req.now_y});
  assign sqx_a = dx_a * dx_a;
  assign sqy_a = dy_a * dy_a;

  assign dnu_a = $signed({1'b0, center_x_q}) - $signed({1'b0, in_req.now_x});
  assign dnv_a = $signed({1'b0, center_y_q}) - $signed({1'b0, in_req.now_y});
  assign dpu_a = $signed({1'b0, center_x_q}) - $signed({1'b0, in_req.prev_x});
  assign dpv_a = $signed({1'b0, center_y_q}) - $signed({1'b0, in_req.prev_y});
  assign ifx_s = $signed({1'b0, inv_fx_q});
  assign ify_s = $signed({1'b0, inv_fy_q});

  assign border_ok_a = (in_req.now_x >= BordLo) && (in_req.now_x <= XHi) &&
                       (in_req.now_y >= BordLo) && (in_req.now_y <= YHi);

  // -------------------------------------------------------------------------
  // Compute stage registers
  // -------------------------------------------------------------------------
  logic [fbf_pkg::ID_W-1:0] b_id_q;
  logic                     b_new_q, b_fs_q, b_border_ok_q;
  logic [2*PosW-1:0]        b_sqx_q, b_sqy_q;
  logic signed [ProdW-1:0]  b_pnu_q, b_pnv_q, b_ppu_q, b_ppv_q;
  logic [AddrW-1:0]         b_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (accept) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_id_q        <= in_req.feature_id;
      b_new_q       <= in_req.is_new;
      b_fs_q        <= in_req.frame_start;
      b_border_ok_q <= border_ok_a;
      b_sqx_q       <= sqx_a[2*PosW-1:0];
      b_sqy_q       <= sqy_a[2*PosW-1:0];
      b_pnu_q       <= dnu_a * ifx_s;
      b_pnv_q       <= dnv_a * ify_s;
      b_ppu_q       <= dpu_a * ifx_s;
      b_ppv_q       <= dpv_a * ify_s;
      b_idx_q       <= idx_a;
    end
  end

  // -------------------------------------------------------------------------
  // Cell count memory: read on accept, write back from the compute stage
  // -------------------------------------------------------------------------
  logic [CntW-1:0]     cnt_mem [NumCells];
  logic [CntW-1:0]     rd_q, fwd_data_q, cnt_b, wr_data;
  logic                fwd_hit_q;
  logic [NumCells-1:0] cnt_vld_q, cnt_vld_d;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= cnt_mem[idx_a];
    end
    if (wr_en) begin
      cnt_mem[b_idx_q] <= wr_data;
    end
  end

  // forward a write that lands in the same cycle as the read of its cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (accept) begin
      fwd_hit_q <= wr_en && (b_idx_q == idx_a);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= wr_data;
    end
  end

  // per-cell valid flags; frame start clears them all before the write
  always_comb begin
    cnt_vld_d = cnt_vld_q;
    if (b_adv && b_fs_q) begin
      cnt_vld_d = '0;
    end
    if (wr_en) begin
      cnt_vld_d[b_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else begin
      cnt_vld_q <= cnt_vld_d;
    end
  end

  // effective count seen by the request in the compute stage
  always_comb begin
    priority if (b_fs_q) begin
      cnt_b = '0;
    end else if (fwd_hit_q) begin
      cnt_b = fwd_data_q;
    end else if (cnt_vld_q[b_idx_q]) begin
      cnt_b = rd_q;
    end else begin
      cnt_b = '0;
    end
  end

  // -------------------------------------------------------------------------
  // Keep decision
  // -------------------------------------------------------------------------
  logic dist_ok;

  assign dist_ok = ({1'b0, b_sqx_q} + {1'b0, b_sqy_q}) <= {1'b0, lim2_q};
  assign keep_b  = dist_ok && b_border_ok_q && (cnt_b < CntMax);
  assign wr_en   = b_adv && keep_b;
  assign wr_data = cnt_b + CntW'(1);

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic [fbf_pkg::ID_W-1:0]  c_id_q;
  logic signed [CoordW-1:0]  c_nu_q, c_nv_q, c_pu_q, c_pv_q;
  logic                      c_new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (wr_en) begin
      c_valid_q <= 1'b1;
    end else if (out_res.ready) begin
      c_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      c_id_q  <= b_id_q;
      c_nu_q  <= round_sat(b_pnu_q);
      c_nv_q  <= round_sat(b_pnv_q);
      c_pu_q  <= round_sat(b_ppu_q);
      c_pv_q  <= round_sat(b_ppv_q);
      c_new_q <= b_new_q;
    end
  end

  assign out_res.valid      = c_valid_q;
  assign out_res.kept_id    = c_id_q;
  assign out_res.now_u      = c_nu_q;
  assign out_res.now_v      = c_nv_q;
  assign out_res.prev_u     = c_pu_q;
  assign out_res.prev_v     = c_pv_q;
  assign out_res.prev_valid = c_new_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_NEXT(a_kept_shows, clk_i, rst_ni, wr_en, c_valid_q)
  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, b_valid_q, cnt_b <= CntMax)
  `ASSERT_IMPL(a_take_while_held, clk_i, rst_ni, c_valid_q && !b_valid_q, in_req.ready)
  `ASSERT_NEXT(a_frame_clear, clk_i, rst_ni, b_adv && b_fs_q && !wr_en, cnt_vld_q == '0)

endmodule

@@ hw/rtl/fbf_axis_cell.sv @@
// Grid cell along one axis from a Q10.6 position.
// cell = floor((pos - BORDER*64) * CELLS / span), clamped, computed as the
// number of cell boundaries the position has reached.
module fbf_axis_cell #(
  parameter int SIZE   = 744,
  parameter int CELLS  = 12,
  parameter int BORDER = 20,
  localparam int CellW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic [fbf_pkg::POS_W-1:0] pos_i,
  output logic [CellW-1:0]          cell_o
);

  localparam int Span = (SIZE - 2 * BORDER) * 64;

  // ge[k]: position lies at or past the lower edge of cell k
  logic [CELLS:0] ge;

  assign ge[0]     = 1'b1;
  assign ge[CELLS] = 1'b0;

  for (genvar k = 1; k < CELLS; k++) begin : g_edge
    // smallest position whose scaled offset reaches k*span
    localparam int Thr = BORDER * 64 + (k * Span + CELLS - 1) / CELLS;
    assign ge[k] = (Span > 0) && ({1'b0, pos_i} >= 17'(Thr));
  end

  // thermometer to index
  always_comb begin
    cell_o = '0;
    for (int k = 1; k < CELLS; k++) begin
      if (ge[k] && !ge[k+1]) begin
        cell_o = CellW'(k);
      end
    end
  end

endmodule
